/* rtl/mpd_pkg.sv */
// shared constants, codes and transaction types for the motor pwm packet dispatcher
package mpd_pkg;

  localparam int NUM_CHANNELS = 32;
  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic [1:0] MODE_ACTIVATE = 2'd0;
  localparam logic [1:0] MODE_SET      = 2'd1;
  localparam logic [1:0] MODE_XMIT     = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [4:0]         channel;
    logic signed [15:0] drive_value;
  } req_t;

  typedef struct packed {
    logic [7:0] address_byte;
    logic [7:0] forward_byte;
    logic [7:0] reverse_byte;
    logic [7:0] check_byte;
    logic       last_packet;
  } pkt_t;

  typedef struct packed {
    logic rd_scan;
    logic do_activate;
    logic do_capture;
    logic do_set_write;
    logic scan_start;
    logic scan_next;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic hot_cur;
    logic more_above;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/mpd_ctrl.sv */
// controller state machine for the motor pwm packet dispatcher
module mpd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  logic [1:0]    req_mode,
  input  mpd_pkg::sts_t sts,
  output mpd_pkg::cmd_t cmd
);
  import mpd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SET  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_LOAD = 2'd3;

  logic [1:0] state, state_next;
  logic       accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_scan = (state == S_SCAN) || (state == S_LOAD);
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_mode)
            MODE_ACTIVATE: cmd.do_activate = 1'b1;
            MODE_SET: begin
              cmd.do_capture = 1'b1;
              state_next     = S_SET;
            end
            MODE_XMIT: begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SET: begin
        cmd.do_set_write = 1'b1;
        state_next       = S_IDLE;
      end
      S_SCAN: begin
        // hot channel: memory read is in flight, packet builds in S_LOAD
        if (sts.hot_cur) begin
          state_next = S_LOAD;
        end else if (sts.idx_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (!sts.more_above) begin
            state_next = S_IDLE;
          end else begin
            cmd.scan_next = 1'b1;
            state_next    = S_SCAN;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/mpd_datapath.sv */
// channel table, drive value memory, scan counter and packet output register
module mpd_datapath (
  input  logic          clk,
  input  logic          rst,
  input  mpd_pkg::req_t req,
  input  mpd_pkg::cmd_t cmd,
  output mpd_pkg::sts_t sts,
  output logic          pkt_valid,
  input  logic          pkt_ready,
  output mpd_pkg::pkt_t pkt
);
  import mpd_pkg::*;

  logic [NUM_CHANNELS-1:0] enabled, pending, written, hot;
  logic [NUM_CHANNELS:0]   rest;
  logic [15:0]             mem [NUM_CHANNELS];
  logic [15:0]             rd_data, cur_value;
  logic                    rd_seen;
  logic [IDX_W-1:0]        idx, raddr, req_idx, set_idx;
  logic                    req_ok, set_ok;
  logic [15:0]             set_value;
  logic                    positive;
  logic [7:0]              addr_b, fwd_b, rev_b;
  pkt_t                    pkt_next;

  assign req_idx = IDX_W'(req.channel);
  assign req_ok  = int'(req.channel) < NUM_CHANNELS;
  assign raddr   = cmd.rd_scan ? idx : req_idx;

  // drive value memory with one read port and one write port, registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[raddr];
    rd_seen <= written[raddr];
    if (cmd.do_set_write && set_ok) begin
      mem[set_idx] <= set_value;
    end
  end

  // entries never written read as the reset value of zero
  assign cur_value = rd_seen ? rd_data : 16'd0;

  always_ff @(posedge clk) begin
    if (cmd.do_capture) begin
      set_idx   <= req_idx;
      set_ok    <= req_ok;
      set_value <= req.drive_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= '0;
      pending <= '0;
      written <= '0;
    end else begin
      if (cmd.do_activate && req_ok) begin
        enabled[req_idx] <= 1'b1;
        pending[req_idx] <= 1'b1;
      end
      if (cmd.do_set_write && set_ok) begin
        pending[set_idx] <= (set_value != cur_value);
        written[set_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.scan_start) begin
      idx <= '0;
    end else if (cmd.scan_next) begin
      idx <= idx + 1'b1;
    end
  end

  assign hot = enabled & pending;
  assign rest = {1'b0, hot} >> idx;

  assign sts.hot_cur    = rest[0];
  assign sts.more_above = |rest[NUM_CHANNELS:1];
  assign sts.idx_last   = (idx == IDX_W'(NUM_CHANNELS - 1));
  assign sts.out_free   = !pkt_valid || pkt_ready;

  assign positive = (cur_value != 16'd0) && !cur_value[15];
  assign addr_b   = 8'(idx);
  assign fwd_b    = positive ? cur_value[7:0] : 8'd0;
  assign rev_b    = positive ? 8'd0 : 8'(8'd0 - cur_value[7:0]);

  always_comb begin
    pkt_next.address_byte = addr_b;
    pkt_next.forward_byte = fwd_b;
    pkt_next.reverse_byte = rev_b;
    pkt_next.check_byte   = addr_b ^ fwd_b ^ rev_b;
    pkt_next.last_packet  = !sts.more_above;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pkt <= pkt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
    end else if (cmd.out_load) begin
      pkt_valid <= 1'b1;
    end else if (pkt_ready) begin
      pkt_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!pkt_valid || pkt_ready))
    else $error("packet loaded over an untaken transaction");

  a_load_hot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> hot[idx])
    else $error("packet built for a channel that is not enabled and pending");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> pkt_valid)
    else $error("loaded packet not presented");

  a_table_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_scan |-> (!cmd.do_activate && !cmd.do_set_write))
    else $error("channel table changed during a transmit scan");
`endif

endmodule

/* rtl/motor_pwm_packet_dispatcher_unit.sv */
// top level of the motor pwm packet dispatcher: controller plus datapath
//
//  channel | signals                        | carries
//  --------+--------------------------------+---------------------------------
//  request | req_valid, req_ready, req      | mode, channel, drive_value
//  packet  | pkt_valid, pkt_ready, pkt      | address, fwd, rev, check, last
//
// activate acts on acceptance; set reads the value memory, then writes it in
// S_SET. transmit clears the scan index; S_SCAN then steps over the channels
// and S_LOAD emits a packet per hot one; the scan ends after the last hot
// channel, or at the last channel if none is hot.
// requests are taken only between transactions.
// packet stalls hold the scan at the hot channel; sync reset clears all flags.
module motor_pwm_packet_dispatcher_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  mpd_pkg::req_t req,
  output logic          pkt_valid,
  input  logic          pkt_ready,
  output mpd_pkg::pkt_t pkt
);
  import mpd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_mode  (req.mode),
    .sts       (sts),
    .cmd       (cmd)
  );

  mpd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt)
  );

endmodule
